// ===== rtl/lasr_pkg.sv =====
// Package for the linear attack-sustain-release envelope generator.
// Holds register indexes, request codes and fixed field widths; no dependencies.
package lasr_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_SUSTAIN = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_STEP    = 2'd3;

    // Request kinds carried in the input beat
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Fixed field widths
    localparam int DUR_W   = 32;
    localparam int STEP_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int END_W   = 34;   // attack + sustain + release without overflow

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd1365;

endpackage

// ===== rtl/linear_asr_envelope.sv =====
// Linear ASR envelope: an accepted tick beat passes through SUM_AS, SUM_END and
// CLASS, then in attack or release through the restoring divider (one step per
// quotient bit), then FINISH, which waits for a free output register; the next beat
// is taken once back in IDLE. A restart beat is taken in IDLE and gives no result.
// Reset (synchronous, aresetn low) clears elapsed time and loads register defaults.
// Depends on lasr_pkg.
module linear_asr_envelope
    import lasr_pkg::*;
#(
    parameter int TIME_BITS       = 40,
    parameter int LEVEL_FRAC_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [0] req_type, [7:1] zero
    input  logic                 s_tlast,    // block_end
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [LEVEL_W-1:0]   m_tdata,    // [15:0] level
    output logic [0:0]           m_tuser,    // [0] done_res
    output logic                 m_tlast     // block_end_out
);

    localparam int CW   = (TIME_BITS > END_W) ? TIME_BITS : END_W;
    localparam int QW   = LEVEL_FRAC_BITS + 1;
    localparam int CNTW = $clog2(QW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(QW - 1);
    localparam logic [QW-1:0]   LVL_ONE  = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_AS,
        ST_SUM_END,
        ST_CLASS,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                state_reg;
    logic [DUR_W-1:0]      attack_reg, sustain_reg, release_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [DUR_W:0]        as_reg;
    logic [END_W-1:0]      end_reg;
    logic [DUR_W:0]        rem_reg;
    logic [DUR_W-1:0]      div_reg;
    logic [QW-1:0]         quo_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  done_reg;
    logic                  blk_reg;
    logic                  m_tvalid_reg;
    logic [LEVEL_W-1:0]    m_tdata_reg;
    logic                  m_tuser_reg;
    logic                  m_tlast_reg;

    // Comparison operands at a common width
    logic [CW-1:0]         t_ext, a_ext, as_ext, end_ext, rel_diff;
    logic [TIME_BITS:0]    time_sum;
    logic [DUR_W:0]        rem_shift;
    logic                  rem_ge;
    logic [DUR_W:0]        rem_next;
    logic [QW+LEVEL_W-1:0] lvl_ext;
    logic                  out_free;

    assign t_ext    = CW'(time_reg);
    assign a_ext    = CW'(attack_reg);
    assign as_ext   = CW'(as_reg);
    assign end_ext  = CW'(end_reg);
    assign rel_diff = end_ext - t_ext;

    // Saturating time advance
    assign time_sum = (TIME_BITS + 1)'(time_reg) + (TIME_BITS + 1)'(step_reg);

    // Shared restoring divider step; the first step compares without a shift
    assign rem_shift = (cnt_reg == '0) ? rem_reg : {rem_reg[DUR_W-1:0], 1'b0};
    assign rem_ge    = rem_shift >= (DUR_W + 1)'(div_reg);
    assign rem_next  = rem_ge ? (rem_shift - (DUR_W + 1)'(div_reg)) : rem_shift;

    assign lvl_ext  = (QW + LEVEL_W)'(quo_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= '0;
            sustain_reg <= '0;
            release_reg <= '0;
            step_reg    <= STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data;
                REG_RELEASE: release_reg <= cfg_data;
                REG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, datapath registers and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            time_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop a taken beat unless a new result replaces it this cycle
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata[0] == REQ_RESTART) begin
                            time_reg <= '0;
                        end else begin
                            blk_reg   <= s_tlast;
                            state_reg <= ST_SUM_AS;
                        end
                    end
                end
                ST_SUM_AS: begin
                    as_reg    <= (DUR_W + 1)'(attack_reg) + (DUR_W + 1)'(sustain_reg);
                    state_reg <= ST_SUM_END;
                end
                ST_SUM_END: begin
                    end_reg   <= END_W'(as_reg) + END_W'(release_reg);
                    state_reg <= ST_CLASS;
                end
                ST_CLASS: begin
                    // Pick the phase, set up the divider, then advance time
                    done_reg <= (t_ext > end_ext);
                    cnt_reg  <= '0;
                    if (t_ext == '0) begin
                        quo_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end else if (t_ext <= a_ext) begin
                        rem_reg   <= (DUR_W + 1)'(t_ext[DUR_W-1:0]);
                        div_reg   <= attack_reg;
                        state_reg <= ST_DIV;
                    end else if (t_ext <= as_ext) begin
                        quo_reg   <= LVL_ONE;
                        state_reg <= ST_FINISH;
                    end else if (t_ext <= end_ext) begin
                        rem_reg   <= (DUR_W + 1)'(rel_diff[DUR_W-1:0]);
                        div_reg   <= release_reg;
                        state_reg <= ST_DIV;
                    end else begin
                        quo_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                    if (time_sum[TIME_BITS]) begin
                        time_reg <= '1;
                    end else begin
                        time_reg <= time_sum[TIME_BITS-1:0];
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[QW-2:0], rem_ge};
                    if (cnt_reg == CNT_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FINISH: begin
                    // Hold the result until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= lvl_ext[LEVEL_W-1:0];
                        m_tuser_reg  <= done_reg;
                        m_tlast_reg  <= blk_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // A finished envelope always reports zero level
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("done flag raised with nonzero level");

    // The quotient never exceeds full scale when a result is formed
    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (quo_reg <= LVL_ONE))
        else $error("level above full scale");

    // The divider step counter rests at zero outside the division
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV) |-> (cnt_reg == '0))
        else $error("divider counter active outside division");

    // A restart beat clears elapsed time
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[0] == REQ_RESTART)) |=> (time_reg == '0))
        else $error("restart did not clear elapsed time");

endmodule

// ===== sim/lasr_envelope_checker.sv =====
// Scoreboard for the linear ASR envelope: tracks register writes, predicts each tick's
// level, done flag and block-end echo, and compares them with the result beats.
// Depends on lasr_pkg.
`timescale 1ns / 1ps
module lasr_envelope_checker
    import lasr_pkg::*;
#(
    parameter int TIME_BITS       = 40,
    parameter int LEVEL_FRAC_BITS = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [0] req_type, [7:1] zero
    input  logic                 s_tlast,    // block_end
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [LEVEL_W-1:0]   m_tdata,    // [15:0] level
    input  logic [0:0]           m_tuser,    // [0] done_res
    input  logic                 m_tlast,    // block_end_out
    output int                   fail_count,
    output int                   pending_results
);

    localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;
    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
        logic               block_end;
    } envelope_result_t;

    logic [DUR_W-1:0]  attack_len;
    logic [DUR_W-1:0]  sustain_len;
    logic [DUR_W-1:0]  release_len;
    logic [STEP_W-1:0] tick_step;
    logic [63:0]       envelope_time;

    envelope_result_t  level_queue[$];

    // Level and done flag for a given elapsed time under the current settings.
    function automatic envelope_result_t level_at_time(input logic [63:0] t,
                                                        input logic blk);
        logic [63:0] sustain_end;
        logic [63:0] release_end;
        logic [63:0] quotient;
        envelope_result_t r;
        sustain_end = 64'(attack_len) + 64'(sustain_len);
        release_end = sustain_end + 64'(release_len);
        quotient    = '0;
        r.done      = 1'b0;
        r.block_end = blk;
        if (t == 64'd0) begin
            quotient = '0;
        end else if (t <= 64'(attack_len)) begin
            quotient = (t << LEVEL_FRAC_BITS) / 64'(attack_len);
        end else if (t <= sustain_end) begin
            quotient = 64'd1 << LEVEL_FRAC_BITS;
        end else if (t <= release_end) begin
            quotient = ((release_end - t) << LEVEL_FRAC_BITS) / 64'(release_len);
        end else begin
            r.done = 1'b1;
        end
        r.level = quotient[LEVEL_W-1:0];
        return r;
    endfunction

    // Note a failure, printing only the first REPORT_LIMIT so a broken block stays readable.
    function automatic void note_failure(input string what, input int unsigned want,
                                         input int unsigned got);
        if (fail_count < REPORT_LIMIT) begin
            $error("%s: expected %0d, got %0d", what, want, got);
        end
        fail_count++;
    endfunction

    // Register writes, tick prediction and result comparison, all sampled at the edge.
    always @(posedge aclk) begin
        envelope_result_t want;
        if (!aresetn) begin
            attack_len    = '0;
            sustain_len   = '0;
            release_len   = '0;
            tick_step     = STEP_RESET;
            envelope_time = '0;
            level_queue.delete();
            fail_count    = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ATTACK:  attack_len  = cfg_data;
                    REG_SUSTAIN: sustain_len = cfg_data;
                    REG_RELEASE: release_len = cfg_data;
                    REG_STEP:    tick_step   = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            // A restart clears time; a tick reports the level, then advances time.
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] == REQ_RESTART) begin
                    envelope_time = '0;
                end else begin
                    level_queue.push_back(level_at_time(envelope_time, s_tlast));
                    if (envelope_time > TIME_MAX - 64'(tick_step)) begin
                        envelope_time = TIME_MAX;
                    end else begin
                        envelope_time = envelope_time + 64'(tick_step);
                    end
                end
            end

            if (m_tvalid && m_tready) begin
                if (level_queue.size() == 0) begin
                    note_failure("unexpected result beat, level", 0, 32'(m_tdata));
                end else begin
                    want = level_queue.pop_front();
                    if (m_tdata !== want.level) begin
                        note_failure("level", 32'(want.level), 32'(m_tdata));
                    end
                    if (m_tuser[0] !== want.done) begin
                        note_failure("done_res", 32'(want.done), 32'(m_tuser[0]));
                    end
                    if (m_tlast !== want.block_end) begin
                        note_failure("block_end_out", 32'(want.block_end), 32'(m_tlast));
                    end
                end
            end
        end
        pending_results = level_queue.size();
    end

endmodule

// ===== sim/linear_asr_envelope_test.sv =====
// Top-level testbench for linear_asr_envelope: drives settings and tick/restart beats,
// applies idling and back-pressure, and reports the verdict from lasr_envelope_checker.
// Depends on lasr_pkg, linear_asr_envelope and lasr_envelope_checker.
`timescale 1ns / 1ps
module linear_asr_envelope_test;
    import lasr_pkg::*;

    localparam int TAIL_CYCLES      = 30;
    localparam int HOLD_CYCLES      = 600;
    localparam int HOLD_AFTER_BEATS = 150;
    localparam int ITEMS_PER_MODE   = 290;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [DUR_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [0] req_type, [7:1] zero
    logic                 s_tlast;    // block_end
    logic                 m_tvalid;
    logic                 m_tready;
    logic [LEVEL_W-1:0]   m_tdata;    // [15:0] level
    logic [0:0]           m_tuser;    // [0] done_res
    logic                 m_tlast;    // block_end_out

    int fail_count;
    int pending_results;
    int send_idle_pct = 27;
    int recv_idle_pct = 85;
    int beats_sent    = 0;

    always #5 aclk = ~aclk;

    linear_asr_envelope i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lasr_envelope_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
                if (!held && taken >= HOLD_AFTER_BEATS) begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
            end
        end
    end

    // Offer one beat after a random gap and wait until it is taken.
    task automatic send_beat(input logic req, input logic blk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, req};
        s_tlast  <= blk;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        beats_sent++;
    endtask

    // Let every expected result drain, then give the block time to go idle.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending_results != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers on consecutive edges.
    task automatic load_envelope(input logic [DUR_W-1:0] attack,
                                 input logic [DUR_W-1:0] sustain,
                                 input logic [DUR_W-1:0] rel,
                                 input logic [STEP_W-1:0] step);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ATTACK;
        cfg_data  <= attack;
        @(posedge aclk);
        cfg_index <= REG_SUSTAIN;
        cfg_data  <= sustain;
        @(posedge aclk);
        cfg_index <= REG_RELEASE;
        cfg_data  <= rel;
        @(posedge aclk);
        cfg_index <= REG_STEP;
        cfg_data  <= DUR_W'(step);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random settings: mostly durations a few steps long so every phase is reached,
    // sometimes the extremes or fully random words.
    task automatic pick_envelope();
        int shape;
        logic [STEP_W-1:0] step;
        logic [DUR_W-1:0]  dur[3];
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            foreach (dur[i]) begin
                dur[i] = $urandom_range(0, 1) ? {DUR_W{1'b1}} : {DUR_W{1'b0}};
            end
            step = $urandom_range(0, 1) ? {STEP_W{1'b1}} : STEP_W'($urandom_range(0, 3));
        end else if (shape == 1) begin
            foreach (dur[i]) begin
                dur[i] = $urandom();
            end
            step = STEP_W'($urandom());
        end else begin
            step = STEP_W'($urandom_range(1, 50000));
            foreach (dur[i]) begin
                dur[i] = ($urandom_range(0, 4) == 0) ? {DUR_W{1'b0}} :
                    DUR_W'(step * $urandom_range(0, 12) + $urandom_range(0, step));
            end
        end
        load_envelope(dur[0], dur[1], dur[2], step);
    endtask

    // One envelope run: usually a restart first, then ticks with the odd stray restart.
    task automatic run_envelope_pass(input int ticks);
        if ($urandom_range(0, 9) != 0) begin
            send_beat(REQ_RESTART, 1'($urandom_range(0, 1)));
        end
        repeat (ticks) begin
            send_beat(($urandom_range(0, 29) == 0) ? REQ_RESTART : REQ_TICK,
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Run limit well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("** linear_asr_envelope: FAILED **");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_ATTACK;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: all durations zero, so time zero then finished at once.
        send_beat(REQ_TICK, 1'b0);
        send_beat(REQ_TICK, 1'b1);
        send_beat(REQ_RESTART, 1'b1);
        send_beat(REQ_TICK, 1'b0);
        settle_block();

        // Walk through every phase, landing exactly on each boundary.
        load_envelope(32'd3000, 32'd2000, 32'd5000, 24'd1000);
        send_beat(REQ_RESTART, 1'b0);
        for (int i = 0; i < 12; i++) begin
            send_beat(REQ_TICK, i[0]);
        end
        settle_block();

        // Largest durations and step.
        load_envelope({DUR_W{1'b1}}, {DUR_W{1'b1}}, {DUR_W{1'b1}}, {STEP_W{1'b1}});
        send_beat(REQ_RESTART, 1'b1);
        repeat (3) send_beat(REQ_TICK, 1'b1);
        settle_block();

        // Zero step keeps time at zero.
        load_envelope(32'd1, 32'd0, 32'd0, 24'd0);
        send_beat(REQ_RESTART, 1'b0);
        repeat (2) send_beat(REQ_TICK, 1'b0);
        settle_block();

        // Release-only envelope with a unit step.
        load_envelope(32'd0, 32'd0, 32'd1, 24'd1);
        send_beat(REQ_RESTART, 1'b1);
        repeat (3) send_beat(REQ_TICK, 1'b1);
        settle_block();

        // Random settings and runs under three idling patterns.
        for (int mode = 0; mode < 3; mode++) begin
            int stop_at;
            case (mode)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            stop_at = beats_sent + ITEMS_PER_MODE;
            while (beats_sent < stop_at) begin
                pick_envelope();
                repeat ($urandom_range(2, 5)) run_envelope_pass($urandom_range(1, 50));
                settle_block();
            end
        end

        if (fail_count == 0) begin
            $display("** linear_asr_envelope: PASSED **");
        end else begin
            $display("** linear_asr_envelope: FAILED **");
        end
        $finish;
    end

endmodule
